FILE: sv/bil_pkg.sv
// Package for bounded_indexed_list: sizes, codes, item types and sequencer states.
`default_nettype none
package bil_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    ACT_APPEND = 4'd0,
    ACT_REMOVE = 4'd1,
    ACT_INSERT = 4'd2,
    ACT_ERASE  = 4'd3,
    ACT_READ   = 4'd4,
    ACT_WRITE  = 4'd5,
    ACT_CLEAR  = 4'd6,
    ACT_RESIZE = 4'd7,
    ACT_ASSIGN = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_ROOM  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_RWAIT,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]               action;
    logic [6:0]               position;
    logic signed [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic [1:0]               status;
  } out_item_t;

endpackage
`default_nettype wire

FILE: sv/bounded_indexed_list.sv
// Top level of bounded_indexed_list: sequencer around one entry RAM and its copy path.
// Path, accept to result valid: append, remove, write, clear and failed actions pass
//   through exec and done, read adds a RAM wait; insert and erase add a read and a write per
//   shifted entry (insert also a final put), resize and assign a fill step per filled entry.
// Throughput: one item at a time; the next is taken the cycle after its result is registered.
// Reset (rst_n low, synchronous): count zero, sequencer idle, no result pending; RAM kept.
`default_nettype none
module bounded_indexed_list (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bil_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bil_pkg::out_item_t      out_item
);

  localparam int IW = bil_pkg::IDX_W;
  localparam int CW = bil_pkg::CNT_W;
  localparam int DW = bil_pkg::DATA_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(bil_pkg::DEPTH);

  // control state
  bil_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;       // committed entry count
  logic            out_valid_r, out_valid_nxt;

  // per-item working registers
  logic [3:0]        act_r;
  logic [CW-1:0]     pos_r;
  logic [DW-1:0]     val_r;
  logic [CW-1:0]     idx_r, idx_nxt;     // walk index for shift and fill
  logic [CW-1:0]     newcnt_r, newcnt_nxt;
  bil_pkg::status_t  stat_r, stat_nxt;
  logic [DW-1:0]     rd_r, rd_nxt;
  bil_pkg::out_item_t out_r, out_nxt;

  // RAM port
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic in_acc;
  logic out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != bil_pkg::ST_IDLE);

  bil_ram #(
    .WIDTH(DW),
    .DEPTH(bil_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // item capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_item.action;
      pos_r <= in_item.position;
      val_r <= in_item.item_value;
    end
    idx_r    <= idx_nxt;
    newcnt_r <= newcnt_nxt;
    stat_r   <= stat_nxt;
    rd_r     <= rd_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bil_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    newcnt_nxt    = newcnt_r;
    stat_nxt      = stat_r;
    rd_nxt        = rd_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[IW-1:0];
    ram_wdata     = val_r;
    ram_raddr     = idx_r[IW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bil_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = bil_pkg::ST_EXEC;
        end
      end

      // Check the action against the count or the capacity, then do it or start the walk.
      bil_pkg::ST_EXEC: begin
        newcnt_nxt = cnt_r;
        stat_nxt   = bil_pkg::STAT_OK;
        rd_nxt     = '0;
        state_nxt  = bil_pkg::ST_DONE;
        case (act_r)
          bil_pkg::ACT_APPEND: begin
            if (cnt_r >= DEPTH_C) begin
              stat_nxt = bil_pkg::STAT_ROOM;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = cnt_r[IW-1:0];
              newcnt_nxt = cnt_r + CW'(1);
            end
          end
          bil_pkg::ACT_REMOVE: begin
            if (cnt_r != '0) begin
              newcnt_nxt = cnt_r - CW'(1);
            end
          end
          bil_pkg::ACT_INSERT: begin
            if (pos_r > cnt_r) begin
              stat_nxt = bil_pkg::STAT_RANGE;
            end else if (cnt_r >= DEPTH_C) begin
              stat_nxt = bil_pkg::STAT_ROOM;
            end else begin
              newcnt_nxt = cnt_r + CW'(1);
              if (pos_r == cnt_r) begin
                ram_we    = 1'b1;
                ram_waddr = pos_r[IW-1:0];
              end else begin
                idx_nxt   = cnt_r;
                state_nxt = bil_pkg::ST_SHIFT_RD;
              end
            end
          end
          bil_pkg::ACT_ERASE: begin
            if (pos_r >= cnt_r) begin
              stat_nxt = bil_pkg::STAT_RANGE;
            end else begin
              newcnt_nxt = cnt_r - CW'(1);
              if (pos_r + CW'(1) < cnt_r) begin
                idx_nxt   = pos_r;
                state_nxt = bil_pkg::ST_SHIFT_RD;
              end
            end
          end
          bil_pkg::ACT_READ: begin
            if (pos_r >= cnt_r) begin
              stat_nxt = bil_pkg::STAT_RANGE;
            end else begin
              ram_raddr = pos_r[IW-1:0];
              state_nxt = bil_pkg::ST_RWAIT;
            end
          end
          bil_pkg::ACT_WRITE: begin
            if (pos_r >= cnt_r) begin
              stat_nxt = bil_pkg::STAT_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pos_r[IW-1:0];
            end
          end
          bil_pkg::ACT_CLEAR: begin
            newcnt_nxt = '0;
          end
          bil_pkg::ACT_RESIZE: begin
            if (pos_r > DEPTH_C) begin
              stat_nxt = bil_pkg::STAT_ROOM;
            end else begin
              newcnt_nxt = pos_r;
              if (pos_r > cnt_r) begin
                idx_nxt   = cnt_r;
                state_nxt = bil_pkg::ST_FILL;
              end
            end
          end
          bil_pkg::ACT_ASSIGN: begin
            if (pos_r > DEPTH_C) begin
              stat_nxt = bil_pkg::STAT_ROOM;
            end else begin
              newcnt_nxt = pos_r;
              if (pos_r != '0) begin
                idx_nxt   = '0;
                state_nxt = bil_pkg::ST_FILL;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // Fetch the neighbor: below for insert (walk down), above for erase (walk up).
      bil_pkg::ST_SHIFT_RD: begin
        if (act_r == bil_pkg::ACT_INSERT) begin
          ram_raddr = idx_r[IW-1:0] - IW'(1);
        end else begin
          ram_raddr = idx_r[IW-1:0] + IW'(1);
        end
        state_nxt = bil_pkg::ST_SHIFT_WR;
      end

      bil_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (act_r == bil_pkg::ACT_INSERT) begin
          idx_nxt = idx_r - CW'(1);
          if (idx_r - CW'(1) == pos_r) begin
            state_nxt = bil_pkg::ST_PUT;
          end else begin
            state_nxt = bil_pkg::ST_SHIFT_RD;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          if (idx_r + CW'(2) < cnt_r) begin
            state_nxt = bil_pkg::ST_SHIFT_RD;
          end else begin
            state_nxt = bil_pkg::ST_DONE;
          end
        end
      end

      bil_pkg::ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[IW-1:0];
        state_nxt = bil_pkg::ST_DONE;
      end

      bil_pkg::ST_RWAIT: begin
        rd_nxt    = ram_rdata;
        state_nxt = bil_pkg::ST_DONE;
      end

      bil_pkg::ST_FILL: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r + CW'(1);
        if (idx_r + CW'(1) >= pos_r) begin
          state_nxt = bil_pkg::ST_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      bil_pkg::ST_DONE: begin
        if (out_free) begin
          out_nxt.read_value = rd_r;
          out_nxt.count      = newcnt_r;
          out_nxt.is_empty   = (newcnt_r == '0);
          out_nxt.status     = stat_r;
          out_valid_nxt      = 1'b1;
          cnt_nxt            = newcnt_r;
          state_nxt          = bil_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bil_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above capacity");

  // a failed action leaves the count alone
  a_fail_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bil_pkg::ST_DONE && stat_r != bil_pkg::STAT_OK) |-> newcnt_r == cnt_r)
    else $error("failed action changed the count");

  // a new result only comes out of the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == bil_pkg::ST_DONE)
    else $error("result loaded outside done state");

  // the RAM is written only while an item is being worked
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != bil_pkg::ST_IDLE && state_r != bil_pkg::ST_DONE))
    else $error("RAM write while idle");

  // empty flag agrees with the count in every result
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.is_empty == (out_r.count == '0)))
    else $error("empty flag disagrees with count");

endmodule
`default_nettype wire

FILE: sv/bil_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
